// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL, included by nicsw_back; all sample on clk and skip reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/nicsw_pkg.sv =====
package nicsw_pkg;

	// Register map, by word index
	typedef enum logic [2:0] {
		REG_HDR_MARK_MIN  = 3'd0,
		REG_HDR_MARK_MAX  = 3'd1,
		REG_HDR_SPACE_MIN = 3'd2,
		REG_HDR_SPACE_MAX = 3'd3,
		REG_STOP_SPACE    = 3'd4,
		REG_TOGGLE_CODE   = 3'd5,
		REG_ON_CODE       = 3'd6,
		REG_OFF_CODE      = 3'd7
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;

	// Register reset values
	localparam logic [7:0]  HDR_MARK_MIN_RST  = 8'd144;
	localparam logic [7:0]  HDR_MARK_MAX_RST  = 8'd216;
	localparam logic [7:0]  HDR_SPACE_MIN_RST = 8'd72;
	localparam logic [7:0]  HDR_SPACE_MAX_RST = 8'd108;
	localparam logic [7:0]  STOP_SPACE_RST    = 8'd72;
	localparam logic [31:0] TOGGLE_CODE_RST   = 32'h0100_0001;
	localparam logic [31:0] ON_CODE_RST       = 32'h0100_0002;
	localparam logic [31:0] OFF_CODE_RST      = 32'h0100_0003;

	// Repeat header space window
	localparam logic [7:0] REPEAT_SPACE_MIN = 8'd36;
	localparam logic [7:0] REPEAT_SPACE_MAX = 8'd54;

	// Request types
	typedef enum logic {
		REQ_PULSE  = 1'b0,
		REQ_SWITCH = 1'b1
	} req_type_t;

	// Result events
	typedef enum logic [2:0] {
		EV_BUSY   = 3'd0,
		EV_FRAME  = 3'd1,
		EV_REPEAT = 3'd2,
		EV_REJECT = 3'd3,
		EV_SWITCH = 3'd4
	} event_t;

	// Matched commands
	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_ON     = 2'd2,
		CMD_OFF    = 2'd3
	} cmd_t;

	// Configuration seen by the decoder
	typedef struct packed {
		logic [7:0]  hdr_mark_min;
		logic [7:0]  hdr_mark_max;
		logic [7:0]  hdr_space_min;
		logic [7:0]  hdr_space_max;
		logic [7:0]  stop_space_min;
		logic [31:0] toggle_code;
		logic [31:0] on_code;
		logic [31:0] off_code;
	} cfg_t;

	// Classified pulse pair, as queued between front and back
	typedef struct packed {
		logic is_switch;
		logic hdr_data;
		logic hdr_repeat;
		logic stop;
		logic bit_one;
	} cls_t;

endpackage

// ===== rtl/nicsw_in_if.sv =====
interface nicsw_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] mark_ticks;
	logic [7:0] space_ticks;

	modport source (output valid, output req_type, output mark_ticks, output space_ticks,
		input ready);
	modport sink (input valid, input req_type, input mark_ticks, input space_ticks,
		output ready);
endinterface

// ===== rtl/nicsw_out_if.sv =====
interface nicsw_out_if;
	logic        valid;
	logic        ready;
	logic        switch_out;
	logic [2:0]  frame_event;
	logic [1:0]  matched_command;
	logic [31:0] received_code;
	logic [5:0]  bits_received;

	modport source (output valid, output switch_out, output frame_event,
		output matched_command, output received_code, output bits_received, input ready);
	modport sink (input valid, input switch_out, input frame_event,
		input matched_command, input received_code, input bits_received, output ready);
endinterface

// ===== rtl/nec_ir_command_switch.sv =====
// Path: an input transfer is written into the queue, then decoded from the queue head into
// the output register once that register is empty or its result is transferring.
// Throughput: one item per cycle while neither side stalls; the 2-entry queue and the
// output register let the input and output sides stall on their own.
// Reset (arst_n low): decoder awaits a header, code and bit count zero, switch level off,
// registers at their defaults, queue and output register empty.
module nec_ir_command_switch #(
	parameter int unsigned CODE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	nicsw_in_if.sink                    req,
	nicsw_out_if.source                 rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nicsw_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	nicsw_pkg::cfg_t cfg;
	logic            push_valid;
	logic            push_ready;
	nicsw_pkg::cls_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	nicsw_pkg::cls_t pop_data;

	nicsw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nicsw_front u_front (
		.req        (req),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	nicsw_queue #(
		.WIDTH ($bits(nicsw_pkg::cls_t)),
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	nicsw_back #(
		.CODE_BITS (CODE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/nicsw_regs.sv =====
module nicsw_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nicsw_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output nicsw_pkg::cfg_t             cfg
);

	nicsw_pkg::cfg_t   cfg_q;
	nicsw_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = nicsw_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hdr_mark_min   <= nicsw_pkg::HDR_MARK_MIN_RST;
			cfg_q.hdr_mark_max   <= nicsw_pkg::HDR_MARK_MAX_RST;
			cfg_q.hdr_space_min  <= nicsw_pkg::HDR_SPACE_MIN_RST;
			cfg_q.hdr_space_max  <= nicsw_pkg::HDR_SPACE_MAX_RST;
			cfg_q.stop_space_min <= nicsw_pkg::STOP_SPACE_RST;
			cfg_q.toggle_code    <= nicsw_pkg::TOGGLE_CODE_RST;
			cfg_q.on_code        <= nicsw_pkg::ON_CODE_RST;
			cfg_q.off_code       <= nicsw_pkg::OFF_CODE_RST;
		end else if (wr_en) begin
			unique case (idx)
				nicsw_pkg::REG_HDR_MARK_MIN:  cfg_q.hdr_mark_min   <= pwdata[7:0];
				nicsw_pkg::REG_HDR_MARK_MAX:  cfg_q.hdr_mark_max   <= pwdata[7:0];
				nicsw_pkg::REG_HDR_SPACE_MIN: cfg_q.hdr_space_min  <= pwdata[7:0];
				nicsw_pkg::REG_HDR_SPACE_MAX: cfg_q.hdr_space_max  <= pwdata[7:0];
				nicsw_pkg::REG_STOP_SPACE:    cfg_q.stop_space_min <= pwdata[7:0];
				nicsw_pkg::REG_TOGGLE_CODE:   cfg_q.toggle_code    <= pwdata;
				nicsw_pkg::REG_ON_CODE:       cfg_q.on_code        <= pwdata;
				nicsw_pkg::REG_OFF_CODE:      cfg_q.off_code       <= pwdata;
				default:                      cfg_q <= cfg_q;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			nicsw_pkg::REG_HDR_MARK_MIN:  prdata = 32'(cfg_q.hdr_mark_min);
			nicsw_pkg::REG_HDR_MARK_MAX:  prdata = 32'(cfg_q.hdr_mark_max);
			nicsw_pkg::REG_HDR_SPACE_MIN: prdata = 32'(cfg_q.hdr_space_min);
			nicsw_pkg::REG_HDR_SPACE_MAX: prdata = 32'(cfg_q.hdr_space_max);
			nicsw_pkg::REG_STOP_SPACE:    prdata = 32'(cfg_q.stop_space_min);
			nicsw_pkg::REG_TOGGLE_CODE:   prdata = cfg_q.toggle_code;
			nicsw_pkg::REG_ON_CODE:       prdata = cfg_q.on_code;
			nicsw_pkg::REG_OFF_CODE:      prdata = cfg_q.off_code;
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== rtl/nicsw_front.sv =====
module nicsw_front (
	nicsw_in_if.sink              req,
	input  nicsw_pkg::cfg_t       cfg,
	output logic                  push_valid,
	input  logic                  push_ready,
	output nicsw_pkg::cls_t       push_data
);

	logic mark_ok;
	logic data_space_ok;
	logic rep_space_ok;

	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	// Window checks against the header limits
	assign mark_ok = (req.mark_ticks >= cfg.hdr_mark_min) &&
		(req.mark_ticks <= cfg.hdr_mark_max);
	assign data_space_ok = (req.space_ticks >= cfg.hdr_space_min) &&
		(req.space_ticks <= cfg.hdr_space_max);
	assign rep_space_ok = (req.space_ticks >= nicsw_pkg::REPEAT_SPACE_MIN) &&
		(req.space_ticks <= nicsw_pkg::REPEAT_SPACE_MAX);

	// Classify the pair; the data window wins over the repeat window
	always_comb begin
		push_data.is_switch  = (req.req_type == nicsw_pkg::REQ_SWITCH);
		push_data.hdr_data   = mark_ok && data_space_ok;
		push_data.hdr_repeat = mark_ok && !data_space_ok && rep_space_ok;
		push_data.stop       = req.space_ticks >= cfg.stop_space_min;
		push_data.bit_one    = {1'b0, req.space_ticks} >= {req.mark_ticks, 1'b0};
	end

endmodule

// ===== rtl/nicsw_queue.sv =====
module nicsw_queue #(
	parameter int unsigned WIDTH = 5,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/nicsw_back.sv =====
`include "assert_macros.svh"

module nicsw_back #(
	parameter int unsigned CODE_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  nicsw_pkg::cfg_t cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  nicsw_pkg::cls_t pop_data,
	nicsw_out_if.source     rsp
);

	localparam int unsigned CNT_W = $clog2(CODE_BITS + 1);

	typedef enum logic [3:0] {
		PH_AWAIT   = 4'b0001,
		PH_BITS    = 4'b0010,
		PH_REPEAT  = 4'b0100,
		PH_DISCARD = 4'b1000
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [CODE_BITS-1:0]   shift_q, shift_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [CNT_W-1:0]       cnt_inc;
	logic                   level_q, level_d;
	nicsw_pkg::event_t      ev_d;
	nicsw_pkg::cmd_t        cmd_d, fin_cmd;
	logic                   full_frame;
	logic                   pop;

	logic                   valid_q;
	logic                   sw_q;
	nicsw_pkg::event_t      ev_q;
	nicsw_pkg::cmd_t        cmd_q;
	logic [31:0]            code_q;
	logic [5:0]             bits_q;

	assign pop_ready = !valid_q || rsp.ready;
	assign pop       = pop_valid && pop_ready;
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign full_frame = cnt_q == CNT_W'(CODE_BITS);

	// Match a complete frame against the codes in priority order
	always_comb begin
		priority if (!full_frame) begin
			fin_cmd = nicsw_pkg::CMD_NONE;
		end else if (64'(shift_q) == 64'(cfg.toggle_code)) begin
			fin_cmd = nicsw_pkg::CMD_TOGGLE;
		end else if (64'(shift_q) == 64'(cfg.on_code)) begin
			fin_cmd = nicsw_pkg::CMD_ON;
		end else if (64'(shift_q) == 64'(cfg.off_code)) begin
			fin_cmd = nicsw_pkg::CMD_OFF;
		end else begin
			fin_cmd = nicsw_pkg::CMD_NONE;
		end
	end

	// Decode the next state for the item at the head of the queue
	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		cnt_d   = cnt_q;
		level_d = level_q;
		ev_d    = nicsw_pkg::EV_BUSY;
		cmd_d   = nicsw_pkg::CMD_NONE;
		if (pop_data.is_switch) begin
			level_d = !level_q;
			ev_d    = nicsw_pkg::EV_SWITCH;
		end else begin
			unique case (phase_q)
				PH_AWAIT: begin
					if (pop_data.hdr_data) begin
						phase_d = PH_BITS;
						shift_d = '0;
						cnt_d   = '0;
					end else if (pop_data.hdr_repeat) begin
						phase_d = PH_REPEAT;
					end else begin
						cnt_d = '0;
						ev_d  = nicsw_pkg::EV_REJECT;
					end
				end
				PH_BITS: begin
					if (pop_data.stop) begin
						phase_d = PH_AWAIT;
						ev_d    = nicsw_pkg::EV_FRAME;
						cmd_d   = fin_cmd;
					end else begin
						shift_d = {shift_q[CODE_BITS-2:0], pop_data.bit_one};
						cnt_d   = cnt_inc;
						if (cnt_inc == CNT_W'(CODE_BITS)) begin
							phase_d = PH_DISCARD;
						end
					end
				end
				PH_REPEAT: begin
					if (pop_data.stop) begin
						phase_d = PH_AWAIT;
						ev_d    = nicsw_pkg::EV_REPEAT;
					end else begin
						cnt_d   = '0;
						phase_d = PH_DISCARD;
					end
				end
				PH_DISCARD: begin
					if (pop_data.stop) begin
						phase_d = PH_AWAIT;
						ev_d    = nicsw_pkg::EV_FRAME;
						cmd_d   = fin_cmd;
					end
				end
				default: phase_d = PH_AWAIT;
			endcase
			unique case (cmd_d)
				nicsw_pkg::CMD_TOGGLE: level_d = !level_q;
				nicsw_pkg::CMD_ON:     level_d = 1'b1;
				nicsw_pkg::CMD_OFF:    level_d = 1'b0;
				default:               level_d = level_q;
			endcase
		end
	end

	// Update decoder state on each transfer out of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_AWAIT;
			shift_q <= '0;
			cnt_q   <= '0;
			level_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				shift_q <= shift_d;
				cnt_q   <= cnt_d;
				level_q <= level_d;
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk) begin
		if (pop) begin
			sw_q   <= level_d;
			ev_q   <= ev_d;
			cmd_q  <= cmd_d;
			code_q <= 32'(shift_d);
			bits_q <= 6'(cnt_d);
		end
	end

	assign rsp.valid           = valid_q;
	assign rsp.switch_out      = sw_q;
	assign rsp.frame_event     = ev_q;
	assign rsp.matched_command = cmd_q;
	assign rsp.received_code   = code_q;
	assign rsp.bits_received   = bits_q;

	`ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CODE_BITS), "bit count above frame length")
	`ASSERT_NOW(a_bits_short, phase_q == PH_BITS, cnt_q < CNT_W'(CODE_BITS),
		"taking bits with a full frame")
	`ASSERT_NOW(a_match_frame, valid_q && cmd_q != nicsw_pkg::CMD_NONE,
		ev_q == nicsw_pkg::EV_FRAME, "command matched outside a frame end")
	`ASSERT_NEXT(a_switch_flip, pop && pop_data.is_switch, level_q != $past(level_q),
		"switch press did not flip the output")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int CODE_BITS = 32;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {
		DEC_WAIT_HDR = 2'd0,
		DEC_BITS     = 2'd1,
		DEC_REPEAT   = 2'd2,
		DEC_DISCARD  = 2'd3
	} dec_phase_t;

	typedef struct packed {
		logic                  level;
		nicsw_pkg::event_t     ev;
		nicsw_pkg::cmd_t       cmd;
		logic [31:0]           code;
		logic [5:0]            nbits;
	} ir_result_t;

	// Decoder mirror: tracks frame state and switch level, queues the expected results
	class switch_tracker;
		nicsw_pkg::cfg_t setup;
		dec_phase_t      phase;
		logic [31:0]     shift_code;
		logic [5:0]      bit_count;
		logic            level;
		ir_result_t      expected_q[$];
		int              mismatches;
		int              seen_by_event[5];
		int              commands_hit;

		function new();
			setup = '{nicsw_pkg::HDR_MARK_MIN_RST, nicsw_pkg::HDR_MARK_MAX_RST,
				nicsw_pkg::HDR_SPACE_MIN_RST, nicsw_pkg::HDR_SPACE_MAX_RST,
				nicsw_pkg::STOP_SPACE_RST, nicsw_pkg::TOGGLE_CODE_RST,
				nicsw_pkg::ON_CODE_RST, nicsw_pkg::OFF_CODE_RST};
			phase = DEC_WAIT_HDR;
			shift_code = '0;
			bit_count = '0;
			level = 1'b0;
			mismatches = 0;
			commands_hit = 0;
			foreach (seen_by_event[i]) seen_by_event[i] = 0;
		endfunction

		// Close the frame; only a full-length code can match, first match wins
		function nicsw_pkg::cmd_t close_frame();
			phase = DEC_WAIT_HDR;
			if (bit_count != CODE_BITS) return nicsw_pkg::CMD_NONE;
			if (shift_code == setup.toggle_code) begin
				level = ~level;
				return nicsw_pkg::CMD_TOGGLE;
			end
			if (shift_code == setup.on_code) begin
				level = 1'b1;
				return nicsw_pkg::CMD_ON;
			end
			if (shift_code == setup.off_code) begin
				level = 1'b0;
				return nicsw_pkg::CMD_OFF;
			end
			return nicsw_pkg::CMD_NONE;
		endfunction

		function void note_item(nicsw_pkg::req_type_t kind, logic [7:0] mark,
				logic [7:0] space);
			ir_result_t exp;
			logic stop;
			logic mark_ok;
			exp.ev = nicsw_pkg::EV_BUSY;
			exp.cmd = nicsw_pkg::CMD_NONE;
			stop = space >= setup.stop_space_min;
			if (kind == nicsw_pkg::REQ_SWITCH) begin
				level = ~level;
				exp.ev = nicsw_pkg::EV_SWITCH;
			end else begin
				case (phase)
					DEC_WAIT_HDR: begin
						mark_ok = mark >= setup.hdr_mark_min && mark <= setup.hdr_mark_max;
						// data window takes priority over the repeat window
						if (mark_ok && space >= setup.hdr_space_min
								&& space <= setup.hdr_space_max) begin
							phase = DEC_BITS;
							shift_code = '0;
							bit_count = '0;
						end else if (mark_ok && space >= nicsw_pkg::REPEAT_SPACE_MIN
								&& space <= nicsw_pkg::REPEAT_SPACE_MAX) begin
							phase = DEC_REPEAT;
						end else begin
							bit_count = '0;
							exp.ev = nicsw_pkg::EV_REJECT;
						end
					end
					DEC_BITS: begin
						if (stop) begin
							exp.cmd = close_frame();
							exp.ev = nicsw_pkg::EV_FRAME;
						end else begin
							// a one when the space is at least twice the mark
							shift_code = {shift_code[30:0], ({1'b0, space} >= {mark, 1'b0})};
							bit_count++;
							if (bit_count >= CODE_BITS) begin
								bit_count = 6'(CODE_BITS);
								phase = DEC_DISCARD;
							end
						end
					end
					DEC_REPEAT: begin
						if (stop) begin
							phase = DEC_WAIT_HDR;
							exp.ev = nicsw_pkg::EV_REPEAT;
						end else begin
							bit_count = '0;
							phase = DEC_DISCARD;
						end
					end
					default: begin
						if (stop) begin
							exp.cmd = close_frame();
							exp.ev = nicsw_pkg::EV_FRAME;
						end
					end
				endcase
			end
			exp.level = level;
			exp.code = shift_code;
			exp.nbits = bit_count;
			seen_by_event[int'(exp.ev)]++;
			if (exp.cmd != nicsw_pkg::CMD_NONE) commands_hit++;
			expected_q.push_back(exp);
		endfunction

		function void check_result(ir_result_t got);
			ir_result_t exp;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing pending: sw=%0b ev=%0d cmd=%0d code=%h bits=%0d",
						got.level, got.ev, got.cmd, got.code, got.nbits);
				return;
			end
			exp = expected_q.pop_front();
			if (got.level !== exp.level || got.ev !== exp.ev || got.cmd !== exp.cmd
					|| got.code !== exp.code || got.nbits !== exp.nbits) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected sw=%0b ev=%0d cmd=%0d code=%h bits=%0d",
						exp.level, exp.ev, exp.cmd, exp.code, exp.nbits);
					$display("          actual   sw=%0b ev=%0d cmd=%0d code=%h bits=%0d",
						got.level, got.ev, got.cmd, got.code, got.nbits);
				end
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [nicsw_pkg::ADDR_W-1:0]  paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	nicsw_in_if  req();
	nicsw_out_if rsp();

	switch_tracker tracker;
	bit calm = 1'b0;
	int items_sent = 0;
	int settings_loaded = 0;
	int cycle_count = 0;

	nec_ir_command_switch #(.CODE_BITS(CODE_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Check each result transfer, then record each input transfer
	always @(posedge clk) begin
		ir_result_t got;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.switch_out, nicsw_pkg::event_t'(rsp.frame_event),
					nicsw_pkg::cmd_t'(rsp.matched_command),
					rsp.received_code, rsp.bits_received};
				tracker.check_result(got);
			end
			if (req.valid && req.ready)
				tracker.note_item(nicsw_pkg::req_type_t'(req.req_type), req.mark_ticks,
					req.space_ticks);
		end
	end

	// Mostly short idle stretches, a few long ones, none while calm
	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(99, 0);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Stall the result side at random
	initial begin
		int stall;
		stall = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && stall > 0) begin
				rsp.ready <= 1'b0;
				stall--;
			end else begin
				rsp.ready <= 1'b1;
				stall = gap_len();
			end
		end
	end

	// Value inside [lo, hi], or anything when the window is empty
	function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi);
		if (lo <= hi) return 8'($urandom_range(hi, lo));
		return 8'($urandom_range(255, 0));
	endfunction

	task automatic write_reg(nicsw_pkg::reg_idx_t idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_config(nicsw_pkg::cfg_t c);
		write_reg(nicsw_pkg::REG_HDR_MARK_MIN, 32'(c.hdr_mark_min));
		write_reg(nicsw_pkg::REG_HDR_MARK_MAX, 32'(c.hdr_mark_max));
		write_reg(nicsw_pkg::REG_HDR_SPACE_MIN, 32'(c.hdr_space_min));
		write_reg(nicsw_pkg::REG_HDR_SPACE_MAX, 32'(c.hdr_space_max));
		write_reg(nicsw_pkg::REG_STOP_SPACE, 32'(c.stop_space_min));
		write_reg(nicsw_pkg::REG_TOGGLE_CODE, c.toggle_code);
		write_reg(nicsw_pkg::REG_ON_CODE, c.on_code);
		write_reg(nicsw_pkg::REG_OFF_CODE, c.off_code);
		tracker.setup = c;
		settings_loaded++;
	endtask

	// Present one item after an optional gap and hold it until the transfer
	task automatic send_item(nicsw_pkg::req_type_t kind, logic [7:0] mark, logic [7:0] space);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.mark_ticks <= mark;
		req.space_ticks <= space;
		do @(posedge clk); while (!req.ready);
		items_sent++;
	endtask

	task automatic send_header(bit is_repeat);
		logic [7:0] mark;
		logic [7:0] space;
		mark = pick(tracker.setup.hdr_mark_min, tracker.setup.hdr_mark_max);
		if (is_repeat)
			space = pick(nicsw_pkg::REPEAT_SPACE_MIN, nicsw_pkg::REPEAT_SPACE_MAX);
		else
			space = pick(tracker.setup.hdr_space_min, tracker.setup.hdr_space_max);
		send_item(nicsw_pkg::REQ_PULSE, mark, space);
	endtask

	// Encode one data bit with a space below the stop threshold (threshold must be nonzero)
	task automatic send_bit(logic one);
		int s;
		int mark;
		int space;
		s = int'(tracker.setup.stop_space_min);
		if (one) begin
			mark = $urandom_range((s - 1) / 2, 0);
			space = $urandom_range(s - 1, 2 * mark);
		end else begin
			mark = $urandom_range(255, 1);
			space = $urandom_range((2 * mark - 1 < s - 1) ? 2 * mark - 1 : s - 1, 0);
		end
		send_item(nicsw_pkg::REQ_PULSE, mark[7:0], space[7:0]);
	endtask

	task automatic send_stop();
		send_item(nicsw_pkg::REQ_PULSE, 8'($urandom_range(255, 0)),
			8'($urandom_range(255, tracker.setup.stop_space_min)));
	endtask

	// Header, bits of a chosen code (mostly full length, some short or long), stop
	task automatic send_frame();
		logic [31:0] code;
		logic b;
		int len;
		int r;
		r = $urandom_range(99, 0);
		if (r < 30) begin
			code = tracker.setup.toggle_code;
		end else if (r < 45) begin
			code = tracker.setup.on_code;
		end else if (r < 60) begin
			code = tracker.setup.off_code;
		end else if (r < 75) begin
			case ($urandom_range(2, 0))
				0: code = tracker.setup.toggle_code;
				1: code = tracker.setup.on_code;
				default: code = tracker.setup.off_code;
			endcase
			code ^= 32'h1 << $urandom_range(31, 0);
		end else begin
			code = $urandom;
		end
		r = $urandom_range(99, 0);
		len = (r < 80) ? CODE_BITS : (r < 90) ? $urandom_range(31, 0) : $urandom_range(40, 33);
		send_header(1'b0);
		if (tracker.setup.stop_space_min != 0) begin
			for (int i = 0; i < len; i++) begin
				b = (i < CODE_BITS) ? code[31 - i] : 1'($urandom_range(1, 0));
				send_bit(b);
			end
		end
		send_stop();
	endtask

	// Repeat header, mostly closed at once, sometimes broken by data pairs
	task automatic send_repeat();
		send_header(1'b1);
		if ($urandom_range(4, 0) != 0 || tracker.setup.stop_space_min == 0) begin
			send_stop();
		end else begin
			repeat ($urandom_range(4, 1)) send_bit(1'($urandom_range(1, 0)));
			send_stop();
		end
	endtask

	task automatic run_random(int count);
		int stop_at;
		int r;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			r = $urandom_range(99, 0);
			if (r < 45)
				send_frame();
			else if (r < 60)
				send_repeat();
			else if (r < 70)
				send_item(nicsw_pkg::REQ_SWITCH, 8'($urandom_range(255, 0)),
					8'($urandom_range(255, 0)));
			else
				send_item(nicsw_pkg::REQ_PULSE, 8'($urandom_range(255, 0)),
					8'($urandom_range(255, 0)));
		end
	endtask

	// Drop valid and wait until every expected result is back
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_q.size() != 0);
	endtask

	initial begin
		nicsw_pkg::cfg_t c;
		tracker = new();
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.req_type <= nicsw_pkg::REQ_PULSE;
		req.mark_ticks <= '0;
		req.space_ticks <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Switch presses ignore mark and space
		send_item(nicsw_pkg::REQ_SWITCH, 8'd255, 8'd255);
		send_item(nicsw_pkg::REQ_SWITCH, 8'd0, 8'd0);
		// Rejected headers: mark just outside, space between or beyond windows, extremes
		send_item(nicsw_pkg::REQ_PULSE, 8'd143, 8'd90);
		send_item(nicsw_pkg::REQ_PULSE, 8'd217, 8'd90);
		send_item(nicsw_pkg::REQ_PULSE, 8'd180, 8'd60);
		send_item(nicsw_pkg::REQ_PULSE, 8'd180, 8'd109);
		send_item(nicsw_pkg::REQ_PULSE, 8'd0, 8'd0);
		send_item(nicsw_pkg::REQ_PULSE, 8'd255, 8'd255);
		send_item(nicsw_pkg::REQ_PULSE, 8'd180, 8'd35);
		// Short frame on the window edges, bits on both sides of the 2x threshold
		send_item(nicsw_pkg::REQ_PULSE, 8'd144, 8'd72);
		send_item(nicsw_pkg::REQ_PULSE, 8'd0, 8'd0);
		send_item(nicsw_pkg::REQ_PULSE, 8'd255, 8'd71);
		send_item(nicsw_pkg::REQ_PULSE, 8'd10, 8'd20);
		send_item(nicsw_pkg::REQ_PULSE, 8'd10, 8'd19);
		send_item(nicsw_pkg::REQ_PULSE, 8'd35, 8'd71);
		send_item(nicsw_pkg::REQ_PULSE, 8'd100, 8'd100);
		// Clean repeat
		send_item(nicsw_pkg::REQ_PULSE, 8'd216, 8'd36);
		send_item(nicsw_pkg::REQ_PULSE, 8'd0, 8'd72);
		// Malformed repeat with a press in the middle
		send_item(nicsw_pkg::REQ_PULSE, 8'd144, 8'd54);
		send_item(nicsw_pkg::REQ_PULSE, 8'd20, 8'd40);
		send_item(nicsw_pkg::REQ_SWITCH, 8'd170, 8'd85);
		send_item(nicsw_pkg::REQ_PULSE, 8'd50, 8'd50);
		send_item(nicsw_pkg::REQ_PULSE, 8'd3, 8'd255);
		// Frame closed with no bits
		send_item(nicsw_pkg::REQ_PULSE, 8'd216, 8'd108);
		send_item(nicsw_pkg::REQ_PULSE, 8'd0, 8'd255);
		run_random(230);
		drain();

		// Data window overlapping the repeat window
		c.hdr_mark_min = 8'($urandom_range(200, 0));
		c.hdr_mark_max = c.hdr_mark_min + 8'($urandom_range(55, 0));
		c.hdr_space_min = 8'd40;
		c.hdr_space_max = 8'd120;
		c.stop_space_min = 8'($urandom_range(255, 20));
		c.toggle_code = $urandom;
		c.on_code = $urandom;
		c.off_code = $urandom;
		load_config(c);
		run_random(220);
		drain();

		// Widest windows, stop only at saturation, extreme codes, no idling
		calm = 1'b1;
		load_config('{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h8000_0000});
		run_random(150);
		drain();
		calm = 1'b0;

		// Empty mark and space windows
		load_config('{8'd255, 8'd0, 8'd200, 8'd100, 8'd1, 32'h7FFF_FFFF, $urandom, $urandom});
		run_random(60);
		drain();

		// Zero-width windows at the bottom, every space stops
		load_config('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, $urandom, $urandom, $urandom});
		run_random(80);
		drain();

		// Random settings at full rate
		calm = 1'b1;
		c.hdr_mark_min = 8'($urandom_range(200, 0));
		c.hdr_mark_max = c.hdr_mark_min + 8'($urandom_range(55, 0));
		c.hdr_space_min = 8'($urandom_range(180, 0));
		c.hdr_space_max = c.hdr_space_min + 8'($urandom_range(75, 0));
		c.stop_space_min = 8'($urandom_range(255, 1));
		c.toggle_code = $urandom;
		c.on_code = $urandom;
		c.off_code = $urandom;
		load_config(c);
		run_random(200);
		drain();
		repeat (4) @(posedge clk);

		$display("covered %0d items under %0d register settings, with and without stalls",
			items_sent, settings_loaded + 1);
		$display("frames %0d (commands hit %0d), repeats %0d, rejected headers %0d, presses %0d",
			tracker.seen_by_event[int'(nicsw_pkg::EV_FRAME)], tracker.commands_hit,
			tracker.seen_by_event[int'(nicsw_pkg::EV_REPEAT)],
			tracker.seen_by_event[int'(nicsw_pkg::EV_REJECT)],
			tracker.seen_by_event[int'(nicsw_pkg::EV_SWITCH)]);
		if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/nicsw_pkg.sv
rtl/nicsw_in_if.sv
rtl/nicsw_out_if.sv
rtl/nicsw_regs.sv
rtl/nicsw_front.sv
rtl/nicsw_queue.sv
rtl/nicsw_back.sv
rtl/nec_ir_command_switch.sv
verif/tb.sv
